@@ rtl/vector_rotate_degrees_assert.svh @@
// assertion macros for the vector rotation block
// used by the top level; needs nothing else
`ifndef VECTOR_ROTATE_DEGREES_ASSERT_SVH
`define VECTOR_ROTATE_DEGREES_ASSERT_SVH

// condition holds at every edge out of reset
`define VRD_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VRD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/vrd_pkg.sv @@
// shared types, constants and elaboration-time functions of the vector rotation block
// no dependencies
package vrd_pkg;

    // angle constants in signed q16.16 degrees
    localparam int DEG360_Q16 = 23592960;
    localparam int DEG180_Q16 = 11796480;
    localparam int DEG90_Q16  = 5898240;

    // quotient bits of the modulo 360 reduction (|angle| <= 2^31 < 128 * 360 deg)
    localparam int QUOT_BITS = 7;

    // angle scale 10^12 = 2^12 * 5^12; the 2^12 part is dropped, only the sign matters
    localparam int ANGLE_SCALE_ODD = 244140625;

    // cordic datapath widths
    localparam int XW = 34;
    localparam int ZW = 54;

    localparam longint K_LIMIT_Q30 = 64'sd652032874;
    localparam longint RAD_DEG_E12 = 64'sd57295779513082;

    localparam longint ATAN_DEG_E12 [17] = '{
        64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926,
        64'sd7125016348902, 64'sd3576334374997, 64'sd1789910608246,
        64'sd895173710211, 64'sd447614170861, 64'sd223810500369,
        64'sd111905677066, 64'sd55952891894, 64'sd27976452617,
        64'sd13988227142, 64'sd6994113675, 64'sd3497056851,
        64'sd1748528427, 64'sd874264214
    };

    typedef enum logic [1:0] {
        QTR_NONE = 2'd0,
        QTR_POS  = 2'd1,
        QTR_NEG  = 2'd2
    } t_quarter;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               neg;
        t_quarter           quarter;
    } t_side;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic               clipped;
    } t_result;

    // atan(2^-i) in the reduced angle units (10^-12 deg * 2^16 / 2^12)
    function automatic logic signed [ZW-1:0] vrd_atan_z(input int i);
        longint t;
        if (i < 17) begin
            t = ATAN_DEG_E12[i[4:0]];
        end else begin
            t = (RAD_DEG_E12 + (64'sd1 <<< (i - 1))) >>> i;
        end
        return ZW'(t <<< 4);
    endfunction

    // start x of the cordic, gain corrected for short stage counts, q1.30
    function automatic longint vrd_gain(input int stages);
        longint k;
        k = K_LIMIT_Q30;
        for (int i = stages; i < 16; i++) begin
            k += (k + (64'sd1 <<< (2 * i))) >>> (2 * i + 1);
        end
        return k;
    endfunction

endpackage

@@ rtl/vrd_if.sv @@
// valid/ready channel interfaces for the vector rotation block
// input item channel and result item channel; no dependencies
interface vrd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] turn_degrees;

    modport source (output valid, output vec_x, output vec_y, output turn_degrees,
                    input ready);
    modport sink   (input valid, input vec_x, input vec_y, input turn_degrees,
                    output ready);
endinterface

interface vrd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic               clipped;

    modport source (output valid, output rot_x, output rot_y, output clipped,
                    input ready);
    modport sink   (input valid, input rot_x, input rot_y, input clipped,
                    output ready);
endinterface

@@ rtl/vrd_cordic_stage.sv @@
// one registered cordic rotation stage
// depends on vrd_pkg for the datapath struct and the arctangent steps
module vrd_cordic_stage
    import vrd_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cordic i_cur,
    output t_cordic o_nxt
);

    localparam logic signed [ZW-1:0] STEP = vrd_atan_z(STAGE);

    t_cordic r_nxt;
    t_cordic n_nxt;
    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;

    always_comb begin
        w_dx = i_cur.y >>> STAGE;
        w_dy = i_cur.x >>> STAGE;
        if (!i_cur.z[ZW-1]) begin
            n_nxt.x = i_cur.x - w_dx;
            n_nxt.y = i_cur.y + w_dy;
            n_nxt.z = i_cur.z - STEP;
        end else begin
            n_nxt.x = i_cur.x + w_dx;
            n_nxt.y = i_cur.y - w_dy;
            n_nxt.z = i_cur.z + STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nxt <= n_nxt;
        end
    end

    assign o_nxt = r_nxt;

endmodule

@@ rtl/vrd_skid.sv @@
// output register with one skid entry for the result channel
// depends on vrd_pkg (t_result) and vrd_out_if
module vrd_skid
    import vrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_data,
    output logic      o_full,
    vrd_out_if.source o_out
);

    logic    r_ov;
    logic    r_sv;
    t_result r_od;
    t_result r_sd;
    logic    w_pop;

    assign w_pop = r_ov && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_pop || !r_ov) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= i_push;
            end
        end else if (i_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop || !r_ov) begin
            r_od <= r_sv ? r_sd : i_data;
        end else if (i_push) begin
            r_sd <= i_data;
        end
    end

    assign o_full        = r_sv;
    assign o_out.valid   = r_ov;
    assign o_out.rot_x   = r_od.rot_x;
    assign o_out.rot_y   = r_od.rot_y;
    assign o_out.clipped = r_od.clipped;

endmodule

@@ rtl/vector_rotate_degrees.sv @@
// Rotates a 2D q16.16 vector counter-clockwise by an angle in q16.16 degrees. The angle is
// reduced modulo 360 with the sign of the input, wrapped into (-180, 180] and folded by a
// quarter turn into [-90, 90]; a gain-compensated cordic of CORDIC_STAGES stages gives cos and
// sin in q1.30, and four 32x32 products rotate the vector. Each component is rounded to
// nearest, saturated to the q16.16 range, and clipped is set when either one saturates. The
// block is fully pipelined: one item enters per clock while the skid entry is free, and each
// item passes through seven compare-subtract steps of the modulo, the wrap, fold and scale
// stages, one register per cordic stage, and the multiply, sum and round stages. The output
// holds a result register plus one skid entry; the pipeline stalls as a whole only when that
// skid entry is full, so input ready is a register.
//
// depends on vrd_pkg, vrd_if, vrd_cordic_stage, vrd_skid and the assertion macro header
`include "vector_rotate_degrees_assert.svh"

module vector_rotate_degrees
    import vrd_pkg::*;
#(
    parameter int CORDIC_STAGES = 18
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vrd_in_if.sink    i_in,
    vrd_out_if.source o_out
);

    // stage map
    localparam int ST_WRAP        = QUOT_BITS + 1;
    localparam int ST_QTR         = QUOT_BITS + 2;
    localparam int ST_SCALE       = QUOT_BITS + 3;
    localparam int ST_CORDIC_LAST = ST_SCALE + CORDIC_STAGES;
    localparam int ST_MUL         = ST_CORDIC_LAST + 1;
    localparam int ST_SUM         = ST_MUL + 1;
    localparam int ST_RND         = ST_SUM + 1;
    localparam int LAT            = ST_RND + 1;

    localparam logic [31:0]         D360_U = 32'(DEG360_Q16);
    localparam logic signed [25:0]  A360   = 26'(DEG360_Q16);
    localparam logic signed [25:0]  A180   = 26'(DEG180_Q16);
    localparam logic signed [25:0]  A90    = 26'(DEG90_Q16);
    localparam logic signed [29:0]  SCALE  = 30'(ANGLE_SCALE_ODD);
    localparam logic signed [XW-1:0] K_Q30 = XW'(vrd_gain(CORDIC_STAGES));
    localparam logic signed [64:0]  RND_HALF = 65'sd536870912;
    localparam logic signed [64:0]  SAT_MAX  = 65'sd2147483647;
    localparam logic signed [64:0]  SAT_MIN  = -65'sd2147483648;

    // pipeline control: everything moves together unless the skid entry is taken
    logic           w_adv;
    logic           w_full;
    logic           w_accept;
    logic [LAT-1:0] r_vld;

    // side data riding along with each item up to the multiply stage
    t_side r_side [0:ST_CORDIC_LAST];
    t_side n_side_q;

    // modulo 360 on the angle magnitude, one quotient bit per stage
    logic [31:0] r_mag [0:QUOT_BITS];
    logic [31:0] n_mag [1:QUOT_BITS];

    // wrapped angle, folded angle
    logic signed [25:0] r_ang_w;
    logic signed [25:0] n_ang_w;
    logic signed [23:0] r_ang_q;
    logic signed [23:0] n_ang_q;
    logic signed [25:0] w_rem;

    // cordic chain
    t_cordic r_cor0;
    t_cordic w_cor [0:CORDIC_STAGES];

    // products, sums, rounded result
    logic signed [31:0] w_cos;
    logic signed [31:0] w_sin;
    logic signed [63:0] r_pxc;
    logic signed [63:0] r_pys;
    logic signed [63:0] r_pxs;
    logic signed [63:0] r_pyc;
    logic signed [64:0] r_sx;
    logic signed [64:0] r_sy;
    logic signed [64:0] w_tx;
    logic signed [64:0] w_ty;
    t_result            r_res;
    t_result            n_res;

    assign w_adv    = !w_full;
    assign i_in.ready = w_adv;
    assign w_accept = i_in.valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // restoring remainder steps, subtracting 360 deg shifted by the quotient bit
    always_comb begin
        for (int k = 0; k < QUOT_BITS; k++) begin
            if (r_mag[k] >= (D360_U << (QUOT_BITS - 1 - k))) begin
                n_mag[k+1] = r_mag[k] - (D360_U << (QUOT_BITS - 1 - k));
            end else begin
                n_mag[k+1] = r_mag[k];
            end
        end
    end

    // truncating remainder takes the sign of the angle, then wrap into (-180, 180]
    // remainder is below 360 deg, so it stays positive in 26 signed bits
    assign w_rem = 26'(r_mag[QUOT_BITS]);

    always_comb begin
        if (!r_side[QUOT_BITS].neg) begin
            n_ang_w = (w_rem > A180) ? w_rem - A360 : w_rem;
        end else begin
            n_ang_w = (w_rem >= A180) ? A360 - w_rem : -w_rem;
        end
    end

    // quarter-turn fold into [-90, 90]
    always_comb begin
        n_side_q = r_side[ST_WRAP];
        if (r_ang_w > A90) begin
            n_side_q.quarter = QTR_POS;
            n_ang_q          = 24'(r_ang_w - A90);
        end else if (r_ang_w < -A90) begin
            n_side_q.quarter = QTR_NEG;
            n_ang_q          = 24'(r_ang_w + A90);
        end else begin
            n_side_q.quarter = QTR_NONE;
            n_ang_q          = 24'(r_ang_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // entry stage: magnitude and sign of the angle
            r_mag[0]          <= i_in.turn_degrees[31] ? 32'(-i_in.turn_degrees)
                                                       : 32'(i_in.turn_degrees);
            r_side[0].vx      <= i_in.vec_x;
            r_side[0].vy      <= i_in.vec_y;
            r_side[0].neg     <= i_in.turn_degrees[31];
            r_side[0].quarter <= QTR_NONE;
            for (int k = 1; k <= QUOT_BITS; k++) begin
                r_mag[k] <= n_mag[k];
            end
            for (int s = 1; s <= ST_CORDIC_LAST; s++) begin
                if (s == ST_QTR) begin
                    r_side[s] <= n_side_q;
                end else begin
                    r_side[s] <= r_side[s-1];
                end
            end
            r_ang_w  <= n_ang_w;
            r_ang_q  <= n_ang_q;
            // cordic start: (K, 0) and the angle in scaled units
            r_cor0.x <= K_Q30;
            r_cor0.y <= '0;
            r_cor0.z <= r_ang_q * SCALE;
        end
    end

    assign w_cor[0] = r_cor0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        vrd_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_cur (w_cor[g]),
            .o_nxt (w_cor[g+1])
        );
    end

    // undo the quarter-turn fold on cos and sin
    always_comb begin
        case (r_side[ST_CORDIC_LAST].quarter)
            QTR_POS: begin
                w_cos = 32'(-w_cor[CORDIC_STAGES].y);
                w_sin = 32'(w_cor[CORDIC_STAGES].x);
            end
            QTR_NEG: begin
                w_cos = 32'(w_cor[CORDIC_STAGES].y);
                w_sin = 32'(-w_cor[CORDIC_STAGES].x);
            end
            default: begin
                w_cos = 32'(w_cor[CORDIC_STAGES].x);
                w_sin = 32'(w_cor[CORDIC_STAGES].y);
            end
        endcase
    end

    // round to nearest and saturate
    assign w_tx = (r_sx + RND_HALF) >>> 30;
    assign w_ty = (r_sy + RND_HALF) >>> 30;

    always_comb begin
        n_res.clipped = 1'b0;
        if (w_tx > SAT_MAX) begin
            n_res.rot_x   = 32'(SAT_MAX);
            n_res.clipped = 1'b1;
        end else if (w_tx < SAT_MIN) begin
            n_res.rot_x   = 32'(SAT_MIN);
            n_res.clipped = 1'b1;
        end else begin
            n_res.rot_x = w_tx[31:0];
        end
        if (w_ty > SAT_MAX) begin
            n_res.rot_y   = 32'(SAT_MAX);
            n_res.clipped = 1'b1;
        end else if (w_ty < SAT_MIN) begin
            n_res.rot_y   = 32'(SAT_MIN);
            n_res.clipped = 1'b1;
        end else begin
            n_res.rot_y = w_ty[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pxc <= r_side[ST_CORDIC_LAST].vx * w_cos;
            r_pys <= r_side[ST_CORDIC_LAST].vy * w_sin;
            r_pxs <= r_side[ST_CORDIC_LAST].vx * w_sin;
            r_pyc <= r_side[ST_CORDIC_LAST].vy * w_cos;
            r_sx  <= 65'(r_pxc) - 65'(r_pys);
            r_sy  <= 65'(r_pxs) + 65'(r_pyc);
            r_res <= n_res;
        end
    end

    vrd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_adv && r_vld[LAT-1]),
        .i_data  (r_res),
        .o_full  (w_full),
        .o_out   (o_out)
    );

    // input is held off only while a result waits at the output
    `VRD_ASSERT_HOLDS(a_ready_stall, i_clk, i_rst_n, i_in.ready || o_out.valid, "ready low with no result waiting")
    // remainder after the reduction steps is below one full turn
    `VRD_ASSERT_IMPLIES(a_rem_range, i_clk, i_rst_n, r_vld[QUOT_BITS], r_mag[QUOT_BITS] < D360_U, "angle remainder not below 360 degrees")
    // folded angle lies within a quarter turn
    `VRD_ASSERT_IMPLIES(a_fold_range, i_clk, i_rst_n, r_vld[ST_QTR], (r_ang_q <= 24'(A90)) && (r_ang_q >= -24'(A90)), "folded angle outside [-90, 90]")
    // a clipped result sits on a bound
    `VRD_ASSERT_IMPLIES(a_clip_bound, i_clk, i_rst_n, o_out.valid && o_out.clipped, (o_out.rot_x == 32'h7FFFFFFF) || (o_out.rot_x == 32'h80000000) || (o_out.rot_y == 32'h7FFFFFFF) || (o_out.rot_y == 32'h80000000), "clipped set with no saturated component")

endmodule
